// ===== rtl/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 digest engine.
package md5_pkg;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 64;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [31:0] K_TABLE [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // Padding phase during a finish
   typedef enum logic [1:0] {
      PH_MARK,
      PH_ZERO,
      PH_LEN
   } pad_phase_type;

   // Round unit operations
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INIT,
      OP_LOAD,
      OP_ROUND,
      OP_ADD
   } round_op_type;

   typedef struct packed {
      round_op_type op;
      logic [5:0]   rnd;
   } round_ctl_type;

   typedef struct packed {
      logic       en;
      logic [3:0] addr;
      logic [1:0] lane;
      logic [7:0] data;
   } buf_wr_type;

   function automatic logic [31:0] md5_k(input logic [5:0] rnd);
      md5_k = K_TABLE[rnd];
   endfunction

   // Rotate amount per round
   function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
      logic [3:0] sel;
      sel = rnd[5:4] * 4'd4 + {2'b00, rnd[1:0]};
      case (sel)
         4'd0:    md5_rot = 5'd7;
         4'd1:    md5_rot = 5'd12;
         4'd2:    md5_rot = 5'd17;
         4'd3:    md5_rot = 5'd22;
         4'd4:    md5_rot = 5'd5;
         4'd5:    md5_rot = 5'd9;
         4'd6:    md5_rot = 5'd14;
         4'd7:    md5_rot = 5'd20;
         4'd8:    md5_rot = 5'd4;
         4'd9:    md5_rot = 5'd11;
         4'd10:   md5_rot = 5'd16;
         4'd11:   md5_rot = 5'd23;
         4'd12:   md5_rot = 5'd6;
         4'd13:   md5_rot = 5'd10;
         4'd14:   md5_rot = 5'd15;
         default: md5_rot = 5'd21;
      endcase
   endfunction

   // Message word used by each round
   function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
      logic [3:0] r;
      r = rnd[3:0];
      case (rnd[5:4])
         2'd0:    md5_msg_idx = r;
         2'd1:    md5_msg_idx = 4'(r * 4'd5 + 4'd1);
         2'd2:    md5_msg_idx = 4'(r * 4'd3 + 4'd5);
         default: md5_msg_idx = 4'(r * 4'd7);
      endcase
   endfunction

endpackage

// ===== rtl/md5_block_buf.sv =====
// 16 x 32-bit message block store with byte-lane writes and a registered read port.
module md5_block_buf (
   input  logic                  clock,
   input  md5_pkg::buf_wr_type   wr,
   input  logic [3:0]            rd_addr,
   output logic [31:0]           rd_data
);

   logic [31:0] mem_ff [md5_pkg::BLOCK_WORDS];
   logic [31:0] rd_data_ff;

   // Byte write into the addressed word
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr][wr.lane*8 +: 8] <= wr.data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/md5_round_unit.sv =====
// Shared MD5 round datapath: working variables, one round per cycle, and chaining words.
module md5_round_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  md5_pkg::round_ctl_type ctl,
   input  logic [31:0]            msg_word,
   output logic [3:0][31:0]       chain
);

   logic [3:0][31:0] chain_ff, chain_in;
   logic [31:0]      a_ff, b_ff, c_ff, d_ff;
   logic [31:0]      a_in, b_in, c_in, d_in;
   logic [31:0]      f_val;
   logic [31:0]      sum;
   logic [63:0]      rot_wide;
   logic [31:0]      rot_val;

   // Round function and rotate
   always_comb begin
      case (ctl.rnd[5:4])
         2'd0:    f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1:    f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum      = a_ff + f_val + md5_pkg::md5_k(ctl.rnd) + msg_word;
      rot_wide = {sum, sum} << md5_pkg::md5_rot(ctl.rnd);
      rot_val  = rot_wide[63:32];
   end

   // Next values per operation
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      chain_in = chain_ff;
      case (ctl.op)
         md5_pkg::OP_INIT: begin
            chain_in = {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
         end
         md5_pkg::OP_LOAD: begin
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
         end
         md5_pkg::OP_ROUND: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + rot_val;
         end
         md5_pkg::OP_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   assign chain = chain_ff;

endmodule

// ===== rtl/md5_digest_engine.sv =====
// MD5 digest engine top level: byte intake, padding sequencer and digest output.
//
// A byte that completes a 64-byte block keeps the engine busy: a load state
// fetches the first message word, 64 rounds run on the single shared round
// unit (one round per cycle, fed by the one read port of the block store),
// and an add state adds into the chaining words. A finish writes its padding
// one byte per cycle (0x80, zeros up to byte 56, then the eight length bytes),
// running one or two compressions along the way, then presents the digest as
// four result beats and restarts from the MD5 initial value. req_ready is
// high only while the engine waits for input.
module md5_digest_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   md5_pkg::state_type     state_ff, state_in;
   md5_pkg::pad_phase_type phase_ff, phase_in;
   logic [5:0]             fill_ff, fill_in;
   logic [63:0]            msg_ff, msg_in;
   logic                   finishing_ff, finishing_in;
   logic                   pad_done_ff, pad_done_in;
   logic [2:0]             len_idx_ff, len_idx_in;
   logic [5:0]             rnd_ff, rnd_in;
   logic [1:0]             word_ff, word_in;

   logic                   absorb_fire;
   logic                   finish_fire;
   logic                   emit_done;
   logic [5:0]             fill_next;
   logic [63:0]            len_bits;
   logic [7:0]             pad_byte;
   md5_pkg::buf_wr_type    buf_wr;
   logic [3:0]             rd_addr;
   logic [31:0]            msg_word;
   md5_pkg::round_ctl_type round_ctl;
   logic [3:0][31:0]       chain;
   logic [31:0]            chain_sel;

   assign absorb_fire = req_valid && req_ready && !req_action;
   assign finish_fire = req_valid && req_ready && req_action;
   assign emit_done   = (state_ff == md5_pkg::ST_EMIT) && rsp_ready && (word_ff == 2'd3);
   assign fill_next   = fill_ff + 6'd1;
   assign len_bits    = {msg_ff[60:0], 3'b000};

   // Padding byte for the current phase
   always_comb begin
      case (phase_ff)
         md5_pkg::PH_MARK: pad_byte = md5_pkg::PAD_MARK;
         md5_pkg::PH_LEN:  pad_byte = len_bits[len_idx_ff*8 +: 8];
         default:          pad_byte = 8'h00;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (absorb_fire && (fill_ff == md5_pkg::LAST_POS)) begin
               state_in = md5_pkg::ST_LOAD;
            end else if (finish_fire) begin
               state_in = md5_pkg::ST_PAD;
            end
         end
         md5_pkg::ST_PAD: begin
            if (fill_ff == md5_pkg::LAST_POS) begin
               state_in = md5_pkg::ST_LOAD;
            end
         end
         md5_pkg::ST_LOAD: begin
            state_in = md5_pkg::ST_ROUND;
         end
         md5_pkg::ST_ROUND: begin
            if (rnd_ff == md5_pkg::LAST_POS) begin
               state_in = md5_pkg::ST_ADD;
            end
         end
         md5_pkg::ST_ADD: begin
            if (!finishing_ff) begin
               state_in = md5_pkg::ST_IDLE;
            end else if (pad_done_ff) begin
               state_in = md5_pkg::ST_EMIT;
            end else begin
               state_in = md5_pkg::ST_PAD;
            end
         end
         md5_pkg::ST_EMIT: begin
            if (emit_done) begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready    = (state_ff == md5_pkg::ST_IDLE);
      rsp_valid    = (state_ff == md5_pkg::ST_EMIT);
      buf_wr.en    = absorb_fire || (state_ff == md5_pkg::ST_PAD);
      buf_wr.addr  = fill_ff[5:2];
      buf_wr.lane  = fill_ff[1:0];
      buf_wr.data  = (state_ff == md5_pkg::ST_PAD) ? pad_byte : req_data_byte;
      round_ctl.rnd = rnd_ff;
      rd_addr       = 4'd0;
      case (state_ff)
         md5_pkg::ST_LOAD: begin
            round_ctl.op = md5_pkg::OP_LOAD;
            rd_addr      = md5_pkg::md5_msg_idx(6'd0);
         end
         md5_pkg::ST_ROUND: begin
            round_ctl.op = md5_pkg::OP_ROUND;
            rd_addr      = md5_pkg::md5_msg_idx(rnd_ff + 6'd1);
         end
         md5_pkg::ST_ADD: begin
            round_ctl.op = md5_pkg::OP_ADD;
         end
         md5_pkg::ST_EMIT: begin
            round_ctl.op = emit_done ? md5_pkg::OP_INIT : md5_pkg::OP_HOLD;
         end
         default: begin
            round_ctl.op = md5_pkg::OP_HOLD;
         end
      endcase
   end

   // Counters and padding bookkeeping
   always_comb begin
      fill_in      = fill_ff;
      msg_in       = msg_ff;
      finishing_in = finishing_ff;
      pad_done_in  = pad_done_ff;
      phase_in     = phase_ff;
      len_idx_in   = len_idx_ff;
      rnd_in       = rnd_ff;
      word_in      = word_ff;
      if (buf_wr.en) begin
         fill_in = fill_next;
      end
      if (absorb_fire) begin
         msg_in = msg_ff + 64'd1;
      end
      if (finish_fire) begin
         finishing_in = 1'b1;
         pad_done_in  = 1'b0;
         phase_in     = md5_pkg::PH_MARK;
         len_idx_in   = 3'd0;
      end
      if (state_ff == md5_pkg::ST_PAD) begin
         if (phase_ff == md5_pkg::PH_LEN) begin
            len_idx_in = len_idx_ff + 3'd1;
            if (len_idx_ff == 3'd7) begin
               pad_done_in = 1'b1;
            end
         end else if (fill_next == md5_pkg::LEN_POS) begin
            phase_in = md5_pkg::PH_LEN;
         end else begin
            phase_in = md5_pkg::PH_ZERO;
         end
      end
      if (state_ff == md5_pkg::ST_LOAD) begin
         rnd_in = 6'd0;
      end else if (state_ff == md5_pkg::ST_ROUND) begin
         rnd_in = rnd_ff + 6'd1;
      end
      if (rsp_valid && rsp_ready) begin
         word_in = word_ff + 2'd1;
      end
      if (emit_done) begin
         fill_in      = 6'd0;
         msg_in       = 64'd0;
         finishing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md5_pkg::ST_IDLE;
         fill_ff      <= 6'd0;
         msg_ff       <= 64'd0;
         finishing_ff <= 1'b0;
         pad_done_ff  <= 1'b0;
         phase_ff     <= md5_pkg::PH_MARK;
         len_idx_ff   <= 3'd0;
         rnd_ff       <= 6'd0;
         word_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         msg_ff       <= msg_in;
         finishing_ff <= finishing_in;
         pad_done_ff  <= pad_done_in;
         phase_ff     <= phase_in;
         len_idx_ff   <= len_idx_in;
         rnd_ff       <= rnd_in;
         word_ff      <= word_in;
      end
   end

   md5_block_buf u_buf (
      .clock   (clock),
      .wr      (buf_wr),
      .rd_addr (rd_addr),
      .rd_data (msg_word)
   );

   md5_round_unit u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (round_ctl),
      .msg_word (msg_word),
      .chain    (chain)
   );

   // Digest bytes come out little-endian per chaining word
   assign chain_sel       = chain[word_ff];
   assign rsp_digest_word = {chain_sel[7:0], chain_sel[15:8], chain_sel[23:16], chain_sel[31:24]};
   assign rsp_word_index  = word_ff;
   assign rsp_last_word   = (word_ff == 2'd3);

`ifndef SYNTHESIS
   // Intake and digest output never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while digest beats pending");

   // Final digest beat returns the engine to a clean idle
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (req_ready && fill_ff == 6'd0))
      else $error("engine not restarted after last digest beat");

   // Rounds advance one per cycle without a break
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::ST_ROUND && rnd_ff != md5_pkg::LAST_POS)
      |=> (state_ff == md5_pkg::ST_ROUND && rnd_ff == $past(rnd_ff) + 6'd1))
      else $error("round sequence broken");

   // A digest always starts at word zero
   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_word_index == 2'd0))
      else $error("digest does not start at word zero");

   // Compression only starts on a full block
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::ST_LOAD) |-> (fill_ff == 6'd0 && $past(buf_wr.en)))
      else $error("compression started on a partial block");
`endif

endmodule
